// ===== hdl/packet_buffer_drop_scheduler_assert.svh =====
// assertion macros for the packet buffer drop scheduler
// needs a clock named clk and an active-low reset named arst_n in scope
`ifndef PACKET_BUFFER_DROP_SCHEDULER_ASSERT_SVH
`define PACKET_BUFFER_DROP_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define PBDS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PBDS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/pbds_pkg.sv =====
// shared types and constants for the packet buffer drop scheduler
// no dependencies
package pbds_pkg;

	localparam int TIME_W    = 40;
	localparam int ARR_W     = 32;
	localparam int PROC_W    = 16;
	localparam int CFG_W     = 7;
	localparam int DEPTH_DEF = 64;

	localparam logic [CFG_W-1:0]  BUF_SIZE_RST = CFG_W'(64);
	localparam logic [TIME_W-1:0] TIME_MAX     = {TIME_W{1'b1}};

	typedef struct packed {
		logic [ARR_W-1:0]  arr_ts;
		logic [PROC_W-1:0] svc_len;
	} in_word_t;

	typedef struct packed {
		logic              dropped;
		logic [TIME_W-1:0] svc_start;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

endpackage

// ===== hdl/pbds_cell.sv =====
// one cell of the finish-time queue: holds one entry, takes its neighbor's on a pop
// depends on pbds_pkg
module pbds_cell import pbds_pkg::*; (
	input  logic              clk,
	input  logic              shift,
	input  logic              load,
	input  logic [TIME_W-1:0] ld_data,
	input  logic [TIME_W-1:0] nxt_data,
	output logic [TIME_W-1:0] finish_q
);

	// pop moves the chain toward the head, insert fills the tail cell
	always_ff @(posedge clk) begin
		if (shift) begin
			finish_q <= nxt_data;
		end else if (load) begin
			finish_q <= ld_data;
		end
	end

endmodule

// ===== hdl/packet_buffer_drop_scheduler.sv =====
// Each packet is handled in steps: an accept step captures the word, then the queue chain
// retires one entry per cycle (head cell compared against the arrival), and a decide step
// inserts or drops the packet, registers the result and raises done.
// A new packet is not accepted while busy.
// A new packet is taken in the same cycle the previous result is shown.
// Reset (arst_n low, asynchronous) empties the queue, clears last finish, sets buffer_size 64.
// The receiver cannot stall; done is high for exactly one cycle per packet.
module packet_buffer_drop_scheduler import pbds_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  in_word_t         item,
	output logic             done,
	output out_word_t        result,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data
);

	`include "packet_buffer_drop_scheduler_assert.svh"

	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

	state_t                state_q;
	logic [CFG_W-1:0]      buf_size_q;
	logic [OCC_W-1:0]      occ_q;
	logic [TIME_W-1:0]     last_finish_q;
	logic [ARR_W-1:0]      arrival_q;
	logic [PROC_W-1:0]     proc_q;
	logic [TIME_W-1:0]     start_q;
	logic                  done_q;
	out_word_t             result_q;

	logic                  accept;
	logic                  pop;
	logic                  decide;
	logic                  full;
	logic [CMP_W-1:0]      cap;
	logic [TIME_W-1:0]     arr_ext;
	logic [TIME_W:0]       sum;
	logic [TIME_W-1:0]     finish;
	logic [TIME_W-1:0]     cell_finish [DEPTH];
	logic [DEPTH-1:0]      cell_load;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign arr_ext = TIME_W'(item.arr_ts);

	// retire the head while it finished at or before the arrival
	assign pop    = (state_q == ST_RUN) && (occ_q != '0)
		&& (cell_finish[0] <= TIME_W'(arrival_q));
	assign decide = (state_q == ST_RUN) && !pop;

	// capacity is buffer_size clipped to the chain length
	assign cap  = (CMP_W'(buf_size_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(buf_size_q);
	assign full = CMP_W'(occ_q) >= cap;

	// finish time with saturation
	assign sum    = {1'b0, start_q} + (TIME_W + 1)'(proc_q);
	assign finish = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

	// chain of queue cells, head at index 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [TIME_W-1:0] nxt;
		if (i == DEPTH - 1) begin : g_last
			assign nxt = cell_finish[i];
		end else begin : g_mid
			assign nxt = cell_finish[i+1];
		end
		assign cell_load[i] = decide && !full && (occ_q == OCC_W'(i));
		pbds_cell u_cell (
			.clk      (clk),
			.shift    (pop),
			.load     (cell_load[i]),
			.ld_data  (finish),
			.nxt_data (nxt),
			.finish_q (cell_finish[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			buf_size_q    <= BUF_SIZE_RST;
			occ_q         <= '0;
			last_finish_q <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= decide;
			if (cfg_we) begin
				buf_size_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (pop) begin
						occ_q <= occ_q - OCC_W'(1);
					end else begin
						state_q <= ST_IDLE;
						if (!full) begin
							occ_q         <= occ_q + OCC_W'(1);
							last_finish_q <= finish;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// input word capture and start time
	always_ff @(posedge clk) begin
		if (accept) begin
			arrival_q <= item.arr_ts;
			proc_q    <= item.svc_len;
			start_q   <= (arr_ext > last_finish_q) ? arr_ext : last_finish_q;
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (decide) begin
			result_q.dropped   <= full;
			result_q.svc_start <= full ? '0 : start_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`PBDS_ASSERT_NXT(a_accept_busy, accept, busy, "accepted word did not raise busy")
	`PBDS_ASSERT_IMP(a_done_idle, done, !busy, "result shown while still busy")
	`PBDS_ASSERT_NXT(a_pop_count, pop, occ_q == $past(occ_q) - OCC_W'(1), "pop lost count")
	`PBDS_ASSERT_IMP(a_occ_bound, 1'b1, CMP_W'(occ_q) <= CMP_W'(DEPTH), "occupancy overflow")

endmodule
